/* hw/rtl/tick_timekeeping_unit_top_macros.svh */
// ----------------------------------------------------------------------------
// Tick timekeeping unit: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_TIMEKEEPING_UNIT_TOP_MACROS_SVH
`define TICK_TIMEKEEPING_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttu: same-cycle check failed");
// next-cycle implication
`define TTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttu: next-cycle check failed");
`else
`define TTU_ASSERT_SAME(lbl, ante, cons)
`define TTU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ttu_pkg.sv */
// ----------------------------------------------------------------------------
// ttu_pkg
// Shared constants, codes and controller/datapath types of the tick
// timekeeping unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ttu_pkg;

  // free-running counter and field widths
  localparam int CNT_W       = 40;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 20;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_USEC_PER_TICK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIT_LATCH       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN_US     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_PRESENT = CFG_IDX_W'(3);

  // register reset values
  localparam logic [19:0] RST_USEC_PER_TICK = 20'd1000;
  localparam logic [15:0] RST_PIT_LATCH     = 16'd1193;
  localparam logic [19:0] RST_TICK_LEN_US   = 20'd1000;

  // item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_OFFSET = 2'd1;
  localparam logic [1:0] MODE_MONO   = 2'd2;

  // arithmetic constants
  localparam int TICKS_PER_US   = 100;
  localparam int ROLLOVER_SLACK = 900;

  // counts to microseconds: 2^37/100 rounded up, exact for any 32-bit count
  localparam logic [31:0] RECIP_US    = 32'h51EB_851F;
  localparam int          RECIP_SHIFT = 37;

  // shared divider geometry: two quotient bits per step
  localparam int DIV_DVD_W       = 36;
  localparam int DIV_DVS_W       = 20;
  localparam int DIV_CNT_W       = 5;
  localparam int DIV_STEPS_WORD  = 16;
  localparam int DIV_STEPS_DELAY = 18;

  typedef enum logic [1:0] {
    DIV_LOST,
    DIV_DELAY
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCALE,
    ST_LOST_START,
    ST_LOST_WAIT,
    ST_DELAY_START,
    ST_DELAY_WAIT,
    ST_TICK_FIN,
    ST_OFFS_FIN,
    ST_MONO_SUM,
    ST_MONO_FIN,
    ST_PUSH
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     mul;
    logic     scale;
    logic     adj;
    logic     load_d;
    logic     cap_lost;
    logic     div_start;
    div_sel_t div_sel;
    logic     tick_fin;
    logic     offs_fin;
    logic     mono_sum;
    logic     mono_fin;
    logic     zero_fin;
    logic     push;
  } ttu_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       counter_present;
    logic       div_done;
    logic       out_free;
  } ttu_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ttu_ifs.sv */
// ----------------------------------------------------------------------------
// ttu_ifs
// Valid/ready channels of the tick timekeeping unit: input items, result
// items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttu_in_if import ttu_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [CNT_W-1:0] counter_value;
  logic [15:0]      pit_count;

  modport source (output valid, mode, counter_value, pit_count, input ready);
  modport sink   (input valid, mode, counter_value, pit_count, output ready);
endinterface

interface ttu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] extra_ticks;
  logic [31:0] offset_us;
  logic [63:0] monotonic_ns;

  modport source (output valid, extra_ticks, offset_us, monotonic_ns, input ready);
  modport sink   (input valid, extra_ticks, offset_us, monotonic_ns, output ready);
endinterface

interface ttu_cfg_if import ttu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ttu_div.sv */
// ----------------------------------------------------------------------------
// ttu_div
// Shared iterative unsigned divider, restoring, two quotient bits a cycle.
// The dividend is left-aligned; after N steps the low 2N bits of the
// quotient register hold the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_div import ttu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_DVD_W-1:0] dividend,
  input  wire logic [DIV_DVS_W-1:0] divisor,
  input  wire logic [DIV_CNT_W-1:0] steps,
  output logic      [DIV_DVD_W-1:0] quotient,
  output logic      [DIV_DVS_W-1:0] remainder,
  output logic                      done
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DVD_W-1:0] q_r, q_nxt;
  logic [DIV_DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_DVS_W-1:0] dvs_r;
  logic [DIV_DVS_W:0]   part1, part2;
  logic [DIV_DVS_W-1:0] rest1;
  logic                 bit1, bit2;

  // two compare/subtract stages per cycle
  always_comb begin
    part1   = {rem_r, q_r[DIV_DVD_W-1]};
    bit1    = part1 >= {1'b0, dvs_r};
    rest1   = bit1 ? DIV_DVS_W'(part1 - {1'b0, dvs_r}) : part1[DIV_DVS_W-1:0];
    part2   = {rest1, q_r[DIV_DVD_W-2]};
    bit2    = part2 >= {1'b0, dvs_r};
    rem_nxt = bit2 ? DIV_DVS_W'(part2 - {1'b0, dvs_r}) : part2[DIV_DVS_W-1:0];
    q_nxt   = {q_r[DIV_DVD_W-3:0], bit1, bit2};
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign done      = busy_r && (cnt_r == '0);

endmodule

`default_nettype wire

/* hw/rtl/ttu_ctrl.sv */
// ----------------------------------------------------------------------------
// ttu_ctrl
// Controller: accepts an item, sequences the divider passes and the
// finishing steps for each mode, then hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_ctrl import ttu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ttu_sts_t sts,
  output ttu_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.mode)
          MODE_TICK: begin
            cmd.mul   = 1'b1;
            cmd.scale = 1'b1;
            state_nxt = ST_SCALE;
          end
          MODE_OFFSET: begin
            cmd.scale = sts.counter_present;
            state_nxt = ST_OFFS_FIN;
          end
          MODE_MONO: begin
            state_nxt = ST_MONO_SUM;
          end
          default: begin
            // undefined mode: all-zero result, state untouched
            cmd.zero_fin = 1'b1;
            state_nxt    = ST_PUSH;
          end
        endcase
      end
      ST_SCALE: begin
        cmd.load_d = 1'b1;
        state_nxt  = ST_LOST_START;
      end
      ST_LOST_START: begin
        cmd.adj       = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LOST;
        state_nxt     = ST_LOST_WAIT;
      end
      ST_LOST_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_lost = 1'b1;
          state_nxt    = ST_DELAY_START;
        end
      end
      ST_DELAY_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DELAY;
        state_nxt     = ST_DELAY_WAIT;
      end
      ST_DELAY_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_TICK_FIN;
        end
      end
      ST_TICK_FIN: begin
        cmd.tick_fin = 1'b1;
        state_nxt    = ST_PUSH;
      end
      ST_OFFS_FIN: begin
        cmd.offs_fin = 1'b1;
        state_nxt    = ST_PUSH;
      end
      ST_MONO_SUM: begin
        cmd.mono_sum = 1'b1;
        state_nxt    = ST_MONO_FIN;
      end
      ST_MONO_FIN: begin
        cmd.mono_fin = 1'b1;
        state_nxt    = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ttu_datapath.sv */
// ----------------------------------------------------------------------------
// ttu_datapath
// Registers, timekeeping state, configuration registers, the shared divider
// and the output register of the tick timekeeping unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_datapath import ttu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ttu_in_if.sink        in_if,
  ttu_out_if.source     out_if,
  ttu_cfg_if.sink       cfg_if,
  input  wire ttu_cmd_t cmd,
  output ttu_sts_t      sts
);

  // configuration registers
  logic [19:0] usec_per_tick_r;
  logic [15:0] pit_latch_r;
  logic [19:0] tick_len_us_r;
  logic        counter_present_r;

  // timekeeping state
  logic [CNT_W-1:0] last_count_r;
  logic [63:0]      mono_base_r;
  logic [31:0]      tick_delay_r;

  // per-item working registers
  logic [1:0]         mode_r;
  logic [CNT_W-1:0]   now_r;
  logic [15:0]        pit_r;
  logic [CNT_W-1:0]   elapsed_r;
  logic [31:0]        us_r;
  logic signed [37:0] c_r;
  logic signed [37:0] num_r;
  logic [31:0]        d_r;
  logic [31:0]        lost_base_r;
  logic [19:0]        rem_keep_r;
  logic [63:0]        sum_r;

  // result and output registers
  logic [31:0] res_extra_r, res_offs_r;
  logic [63:0] res_ns_r;
  logic        out_valid_r;
  logic [31:0] out_extra_r, out_offs_r;
  logic [63:0] out_ns_r;

  // divider hookup
  logic [DIV_DVD_W-1:0] div_dvd;
  logic [DIV_DVS_W-1:0] div_dvs;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_DVD_W-1:0] div_q;
  logic [DIV_DVS_W-1:0] div_rem;
  logic                 div_done;

  // combinational terms
  logic [19:0]        upt_eff;
  logic [15:0]        latch_eff;
  logic [63:0]        us_prod;
  logic signed [16:0] span;
  logic signed [37:0] prod;
  logic signed [37:0] num_nxt;
  logic [37:0]        num_abs;
  logic [31:0]        lost_q;
  logic [31:0]        lost_base_nxt;
  logic [31:0]        nd32;
  logic signed [33:0] slack_diff;
  logic               slack_over;
  logic [63:0]        sum_nxt;
  logic [63:0]        ns_nxt;

  // zero divisors read as one
  assign upt_eff   = (usec_per_tick_r == '0) ? 20'd1 : usec_per_tick_r;
  assign latch_eff = (pit_latch_r == '0) ? 16'd1 : pit_latch_r;

  // elapsed counts to microseconds by reciprocal multiplication
  assign us_prod = 64'(elapsed_r[31:0]) * 64'(RECIP_US);

  // c = ((latch - 1) - pit) * tick length, signed
  assign span    = $signed({1'b0, latch_eff - 16'd1}) - $signed({1'b0, pit_r});
  assign prod    = span * $signed({1'b0, tick_len_us_r});
  assign num_nxt = c_r + $signed({23'b0, latch_eff[15:1]});
  assign num_abs = num_r[37] ? 38'(-num_r) : num_r;

  // lost ticks from the first divider pass
  assign lost_q        = div_q[31:0];
  assign lost_base_nxt = (lost_q >= 32'd2) ? (lost_q - 32'd1) : 32'd0;

  // new delay, rounded quotient truncated toward zero, then the slack test
  assign nd32       = num_r[37] ? (32'd0 - div_q[31:0]) : div_q[31:0];
  assign slack_diff = $signed({14'b0, rem_keep_r}) - $signed({{2{nd32[31]}}, nd32});
  assign slack_over = (slack_diff > 34'(ROLLOVER_SLACK)) ||
                      (slack_diff < -34'(ROLLOVER_SLACK));

  // monotonic sum and scaling by ten nanoseconds per count
  assign sum_nxt = mono_base_r + {{(64-CNT_W){1'b0}}, elapsed_r};
  assign ns_nxt  = {sum_r[60:0], 3'b000} + {sum_r[62:0], 1'b0};

  // divider operand selection
  always_comb begin
    case (cmd.div_sel)
      DIV_LOST: begin
        div_dvd   = {d_r, 4'b0000};
        div_dvs   = upt_eff;
        div_steps = DIV_CNT_W'(DIV_STEPS_WORD);
      end
      DIV_DELAY: begin
        div_dvd   = num_abs[DIV_DVD_W-1:0];
        div_dvs   = {4'b0000, latch_eff};
        div_steps = DIV_CNT_W'(DIV_STEPS_DELAY);
      end
      default: begin
        div_dvd   = '0;
        div_dvs   = 20'd1;
        div_steps = '0;
      end
    endcase
  end

  ttu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .steps     (div_steps),
    .quotient  (div_q),
    .remainder (div_rem),
    .done      (div_done)
  );

  // configuration writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usec_per_tick_r   <= RST_USEC_PER_TICK;
      pit_latch_r       <= RST_PIT_LATCH;
      tick_len_us_r     <= RST_TICK_LEN_US;
      counter_present_r <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_USEC_PER_TICK:   usec_per_tick_r   <= cfg_if.data[19:0];
        CFG_PIT_LATCH:       pit_latch_r       <= cfg_if.data[15:0];
        CFG_TICK_LEN_US:     tick_len_us_r     <= cfg_if.data[19:0];
        CFG_COUNTER_PRESENT: counter_present_r <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // timekeeping state, updated once per tick item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      mono_base_r  <= '0;
      tick_delay_r <= '0;
    end else if (cmd.tick_fin) begin
      last_count_r <= now_r;
      mono_base_r  <= sum_nxt;
      tick_delay_r <= nd32;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_if.mode;
      now_r     <= in_if.counter_value;
      pit_r     <= in_if.pit_count;
      elapsed_r <= in_if.counter_value - last_count_r;
    end
    if (cmd.mul) begin
      c_r <= prod;
    end
    if (cmd.scale) begin
      us_r <= 32'(us_prod[63:RECIP_SHIFT]);
    end
    if (cmd.adj) begin
      num_r <= num_nxt;
    end
    if (cmd.load_d) begin
      d_r <= us_r + tick_delay_r;
    end
    if (cmd.cap_lost) begin
      lost_base_r <= lost_base_nxt;
      rem_keep_r  <= div_rem;
    end
    if (cmd.mono_sum) begin
      sum_r <= sum_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.tick_fin) begin
      res_extra_r <= lost_base_r + {31'b0, slack_over};
      res_offs_r  <= '0;
      res_ns_r    <= '0;
    end else if (cmd.offs_fin) begin
      res_extra_r <= '0;
      res_offs_r  <= tick_delay_r + (counter_present_r ? us_r : 32'd0);
      res_ns_r    <= '0;
    end else if (cmd.mono_fin) begin
      res_extra_r <= '0;
      res_offs_r  <= '0;
      res_ns_r    <= ns_nxt;
    end else if (cmd.zero_fin) begin
      res_extra_r <= '0;
      res_offs_r  <= '0;
      res_ns_r    <= '0;
    end
  end

  // output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_extra_r <= res_extra_r;
      out_offs_r  <= res_offs_r;
      out_ns_r    <= res_ns_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.extra_ticks  = out_extra_r;
  assign out_if.offset_us    = out_offs_r;
  assign out_if.monotonic_ns = out_ns_r;

  // status to the controller
  assign sts.mode            = mode_r;
  assign sts.counter_present = counter_present_r;
  assign sts.div_done        = div_done;
  assign sts.out_free        = !out_valid_r || out_if.ready;

endmodule

`default_nettype wire

/* hw/rtl/tick_timekeeping_unit_top.sv */
// ----------------------------------------------------------------------------
// tick_timekeeping_unit_top
// Tick items: reciprocal multiply for microseconds, then divider passes of 16
// and 18 steps, two quotient bits a cycle; offset queries, monotonic queries
// and mode 3 use no divider pass.
// Items are handled one at a time; the next is taken once the last result is
// in the output register, also while that result waits there for its transfer.
// Reset: synchronous; configuration registers return to defaults, state to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tick_timekeeping_unit_top_macros.svh"

module tick_timekeeping_unit_top import ttu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ttu_in_if.sink    in_if,
  ttu_out_if.source out_if,
  ttu_cfg_if.sink   cfg_if
);

  ttu_cmd_t cmd;
  ttu_sts_t sts;
  logic     in_ready;

  assign in_if.ready = in_ready;

  // sequencing
  ttu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, state and output register
  ttu_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .sts    (sts)
  );

  // checks
  `TTU_ASSERT_NEXT(a_accept_blocks_input, in_if.valid && in_if.ready, !in_if.ready)
  `TTU_ASSERT_SAME(a_push_only_when_free, cmd.push, sts.out_free)
  `TTU_ASSERT_NEXT(a_divider_not_instant, cmd.div_start, !sts.div_done)

endmodule

`default_nettype wire

/* tb/tick_timekeeping_unit_top_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick timekeeping unit: result checker
// Watches the register, item and result channels. Keeps its own copy of the
// timekeeping state, works out the time reading that each item transfer must
// give, and compares each result transfer field by field, oldest first.
// ----------------------------------------------------------------------------

module tick_timekeeping_unit_top_checker import ttu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ttu_in_if    in_ch,
  ttu_out_if   out_ch,
  ttu_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam logic [63:0] NS_PER_COUNT = 64'd10;

  typedef struct packed {
    logic [31:0] extra_ticks;
    logic [31:0] offset_us;
    logic [63:0] monotonic_ns;
  } time_reading_t;

  // readings owed by the block, oldest first
  time_reading_t time_readings[$];

  // register copies
  logic [19:0] usec_per_tick;
  logic [15:0] pit_latch;
  logic [19:0] tick_len_us;
  logic        counter_present;

  // timekeeping state
  logic [CNT_W-1:0] last_count;
  logic [63:0]      mono_base;
  logic [31:0]      tick_delay_us;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got 0x%0h, predicted 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // advance the timekeeping state by one item and queue its reading
  task automatic advance_timekeeping(input logic [1:0] mode, input logic [CNT_W-1:0] now,
                                     input logic [15:0] pit);
    time_reading_t    r;
    logic [CNT_W-1:0] span;
    logic [31:0]      elapsed_us, upt, lost, rem;
    longint           latch, pit_l, size_l, scaled, new_delay, slip;
    int               delay_s;
    r          = '0;
    span       = now - last_count;
    elapsed_us = (now[31:0] - last_count[31:0]) / 32'(TICKS_PER_US);
    case (mode)
      MODE_TICK: begin
        // zero registers count as one
        upt   = (usec_per_tick == '0) ? 32'd1 : 32'(usec_per_tick);
        latch = pit_latch;
        if (latch == 0) latch = 1;
        elapsed_us = elapsed_us + tick_delay_us;
        lost = elapsed_us / upt;
        rem  = elapsed_us % upt;
        r.extra_ticks = (lost >= 32'd2) ? lost - 32'd1 : 32'd0;
        mono_base  = mono_base + 64'(span);
        last_count = now;
        // new delay, signed; a count above the reload value gives a negative product
        pit_l     = pit;
        size_l    = tick_len_us;
        scaled    = (latch - 1 - pit_l) * size_l;
        new_delay = (scaled + latch / 2) / latch;
        tick_delay_us = new_delay[31:0];
        delay_s = tick_delay_us;
        slip    = rem;
        slip    = slip - delay_s;
        if (slip > ROLLOVER_SLACK || slip < -ROLLOVER_SLACK)
          r.extra_ticks = r.extra_ticks + 32'd1;
      end
      MODE_OFFSET: begin
        r.offset_us = counter_present ? tick_delay_us + elapsed_us : tick_delay_us;
      end
      MODE_MONO: begin
        r.monotonic_ns = (mono_base + 64'(span)) * NS_PER_COUNT;
      end
      default: ; // no meaning: all-zero reading, state untouched
    endcase
    time_readings.push_back(r);
  endtask

  always @(posedge clk) begin
    time_reading_t want;
    if (!rst_n) begin
      usec_per_tick   = RST_USEC_PER_TICK;
      pit_latch       = RST_PIT_LATCH;
      tick_len_us     = RST_TICK_LEN_US;
      counter_present = 1'b0;
      last_count      = '0;
      mono_base       = '0;
      tick_delay_us   = '0;
      time_readings.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      // register write transfer
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_USEC_PER_TICK:   usec_per_tick   = cfg_ch.data[19:0];
          CFG_PIT_LATCH:       pit_latch       = cfg_ch.data[15:0];
          CFG_TICK_LEN_US:     tick_len_us     = cfg_ch.data[19:0];
          CFG_COUNTER_PRESENT: counter_present = cfg_ch.data[0];
          default: ;
        endcase
      end
      // result transfer: belongs to an earlier item, so pop before pushing
      if (out_ch.valid && out_ch.ready) begin
        if (time_readings.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(out_ch.extra_ticks), '0);
        end else begin
          want = time_readings.pop_front();
          if (out_ch.extra_ticks !== want.extra_ticks)
            report_mismatch("extra_ticks", 64'(out_ch.extra_ticks), 64'(want.extra_ticks));
          if (out_ch.offset_us !== want.offset_us)
            report_mismatch("offset_us", 64'(out_ch.offset_us), 64'(want.offset_us));
          if (out_ch.monotonic_ns !== want.monotonic_ns)
            report_mismatch("monotonic_ns", out_ch.monotonic_ns, want.monotonic_ns);
        end
      end
      // item transfer
      if (in_ch.valid && in_ch.ready)
        advance_timekeeping(in_ch.mode, in_ch.counter_value, in_ch.pit_count);
      pending = time_readings.size();
    end
  end

endmodule

/* tb/tick_timekeeping_unit_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick timekeeping unit: testbench top
// Drives a directed set of tick marks and queries, then phases of random
// counter histories under several register settings and idle patterns,
// including a long output hold-off. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tick_timekeeping_unit_top_test;
  import ttu_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         PHASES         = 8;
  localparam int         PHASE_ITEMS    = 170;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         LATENCY_TAIL   = 100;
  localparam int         CYCLE_LIMIT    = 1000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // idle percentages, hold-off requests
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int unsigned cycle_count = 0;

  // stimulus shaping: current register values and counter position
  logic [19:0]      upt_now   = RST_USEC_PER_TICK;
  logic [15:0]      latch_now = RST_PIT_LATCH;
  logic [CNT_W-1:0] clock_now = '0;

  ttu_in_if  in_ch();
  ttu_out_if out_ch();
  ttu_cfg_if cfg_ch();

  tick_timekeeping_unit_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tick_timekeeping_unit_top_checker timekeeping_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one item transfer; valid stays high unless the sender idles
  task automatic send_item(input logic [1:0] mode, input logic [CNT_W-1:0] reading,
                           input logic [15:0] pit);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.counter_value <= reading;
    in_ch.pit_count     <= pit;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // write all four registers; block must be idle
  task automatic configure(input logic [CFG_DATA_W-1:0] upt, input logic [CFG_DATA_W-1:0] lat,
                           input logic [CFG_DATA_W-1:0] size,
                           input logic [CFG_DATA_W-1:0] present);
    write_register(CFG_USEC_PER_TICK, upt);
    write_register(CFG_PIT_LATCH, lat);
    write_register(CFG_TICK_LEN_US, size);
    write_register(CFG_COUNTER_PRESENT, present);
    cfg_ch.valid <= 1'b0;
    upt_now   = upt;
    latch_now = lat[15:0];
  endtask

  // mostly a plausible tick history; some queries, meaningless modes and jumps
  task automatic send_random_item();
    logic [63:0]      span, advance;
    logic [CNT_W-1:0] reading;
    logic [15:0]      pit;
    logic [1:0]       mode;
    int unsigned      pick, lapse, lat;
    span = 64'((upt_now == '0) ? 20'd1 : upt_now) * 64'd100;
    lat  = (latch_now == '0) ? 1 : int'(latch_now);
    pit  = 16'($urandom_range(lat - 1));
    if ($urandom_range(9) == 0) pit = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      // tick mark: usually one tick on, sometimes lost ticks or a short one
      lapse = $urandom_range(99);
      lapse = (lapse < 70) ? 1 : (lapse < 88) ? $urandom_range(5, 2) :
              (lapse < 94) ? 0 : $urandom_range(60, 6);
      advance   = span * 64'(lapse) + 64'($urandom) % span;
      clock_now = clock_now + CNT_W'(advance);
      mode      = MODE_TICK;
      reading   = clock_now;
    end else if (pick < 88) begin
      mode    = (pick < 68) ? MODE_OFFSET : MODE_MONO;
      reading = clock_now + CNT_W'(64'($urandom) % (span * 2));
    end else if (pick < 93) begin
      mode    = MODE_UNUSED;
      reading = CNT_W'({$urandom, $urandom});
    end else begin
      // counter jumps to anywhere
      mode      = 2'($urandom_range(2));
      reading   = CNT_W'({$urandom, $urandom});
      clock_now = reading;
      pit       = 16'($urandom);
    end
    send_item(mode, reading, pit);
  endtask

  // stimulus and verdict
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_TICK;
    in_ch.counter_value <= '0;
    in_ch.pit_count     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_USEC_PER_TICK;
    cfg_ch.data         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset registers, counter absent
    send_item(MODE_OFFSET, 40'd0, 16'd0);
    send_item(MODE_MONO, 40'h00_0000_1234, 16'hFFFF);
    // slip of exactly 900, then 901
    send_item(MODE_TICK, 40'd90000, 16'd1192);
    send_item(MODE_TICK, 40'd180100, 16'd1192);
    // slip of -901, then exactly -900
    send_item(MODE_TICK, 40'd280100, 16'd117);
    send_item(MODE_TICK, 40'd290000, 16'd118);
    send_item(MODE_OFFSET, 40'd295000, 16'd0);
    // count above reload value: negative delay
    send_item(MODE_TICK, 40'd390000, 16'hFFFF);
    send_item(MODE_MONO, 40'hFF_FFFF_FFFF, 16'd0);
    send_item(MODE_UNUSED, 40'hFF_FFFF_FFFF, 16'hFFFF);
    send_item(MODE_TICK, 40'hFF_FFFF_FFFF, 16'd0);
    // counter wraps, then a long run of lost ticks
    send_item(MODE_TICK, 40'd0, 16'd1192);
    send_item(MODE_TICK, 40'd50_000_000, 16'd600);

    // zero registers, counter present
    settle_results();
    configure(20'd0, 20'd0, 20'hFFFFF, 20'd1);
    send_item(MODE_OFFSET, 40'd50_000_500, 16'd0);
    send_item(MODE_TICK, 40'd50_100_000, 16'd0);
    send_item(MODE_TICK, 40'd50_200_000, 16'hFFFF);
    send_item(MODE_MONO, 40'd50_300_000, 16'd0);
    send_item(MODE_OFFSET, 40'hFF_FFFF_FFFF, 16'd0);
    clock_now = 40'd50_200_000;

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      settle_results();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      case (p)
        0: configure(20'd1000, 20'd1193, 20'd1000, 20'd1);
        1: configure(20'd1, 20'd1, 20'd1, 20'd0);
        2: configure(20'd1000000, 20'd65535, 20'd1000000, 20'd1);
        // upper bits beyond the 16-bit reload value are dropped
        3: configure(20'hFFFFF, 20'hF0000, 20'hFFFFF, 20'hFFFFF);
        4: configure(20'd0, 20'd100, 20'd0, 20'hFFFFE);
        default: configure(20'($urandom_range(20000, 1)), 20'($urandom_range(65535, 1)),
                           20'($urandom_range(1000000, 1)), 20'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) hold_requests++;
        if (p == 3 && n == 100) settle_results();
        send_random_item();
      end
    end

    settle_results();
    repeat (LATENCY_TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ttu_pkg.sv
hw/rtl/ttu_ifs.sv
hw/rtl/ttu_div.sv
hw/rtl/ttu_ctrl.sv
hw/rtl/ttu_datapath.sv
hw/rtl/tick_timekeeping_unit_top.sv
tb/tick_timekeeping_unit_top_checker.sv
tb/tick_timekeeping_unit_top_test.sv
